[rtl/core/tcp_window_sender_control_unit_defines.svh]
// Assertion macros for the window sender. Both collapse to nothing in synthesis.
`ifndef TCP_WINDOW_SENDER_CONTROL_UNIT_DEFINES_SVH
`define TCP_WINDOW_SENDER_CONTROL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TWS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("window sender assertion failed");
`define TWS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window sender assertion failed");
`else
`define TWS_ASSERT(name, clk, rst_n, prop)
`define TWS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/tws_pkg.sv]
package tws_pkg;

  localparam int unsigned MAX_WIN_SEGS = 64;
  localparam int unsigned TIMER_DEPTH  = 128;
  localparam int unsigned RESULT_LIMIT = 64;

  localparam int unsigned FLIGHT_AW = $clog2(MAX_WIN_SEGS);
  localparam int unsigned TIMER_AW  = $clog2(TIMER_DEPTH);
  localparam int unsigned SEGS_W    = $clog2(MAX_WIN_SEGS + 1);
  localparam int unsigned TCNT_W    = $clog2(TIMER_DEPTH + 1);
  localparam int unsigned NRES_W    = $clog2(RESULT_LIMIT + 1);

  localparam int unsigned SEQ_W   = 24;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned WIN_W   = 23;
  localparam int unsigned TMO_W   = 8;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned DIVN_W  = 32;
  localparam int unsigned CFG_W   = 24;

  localparam logic [WIN_W-1:0] WIN_CAP        = 23'd4194304;
  localparam logic [LEN_W-1:0] SEG_RESET      = 16'd1000;
  localparam logic [SEQ_W-1:0] STREAM_RESET   = 24'd100000;
  localparam logic [WIN_W-1:0] WINDOW_RESET   = 23'd5900;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 8'd1;

  localparam logic [1:0] CFG_SEGMENT = 2'd0;
  localparam logic [1:0] CFG_STREAM  = 2'd1;
  localparam logic [1:0] CFG_WINDOW  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic accept;
    logic tick;
    logic tmo_clear;
    logic resend;
    logic pop_flight;
    logic ack_update;
    logic grow_load;
    logic grow_take;
    logic seg_load;
    logic seg_take;
    logic pop_timer;
    logic send;
    logic status;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic tq_empty;
    logic expired;
    logic done;
    logic flight_pop;
    logic timer_pop;
    logic popped;
    logic div_busy;
    logic can_send;
    logic n_zero;
    logic emit_ok;
    logic out_free;
    logic pend_v;
  } status_t;

endpackage

[rtl/core/tws_ram.sv]
module tws_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/tws_div.sv]
module tws_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tws_pkg::DIVN_W-1:0]  dividend_i,
  input  logic [tws_pkg::WIN_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [tws_pkg::DIVN_W-1:0]  quotient_o
);
  import tws_pkg::*;

  localparam int unsigned CW = $clog2(DIVN_W + 1);

  logic [WIN_W-1:0]  rem_q, rem_d;
  logic [DIVN_W-1:0] quo_q, quo_d;
  logic [WIN_W-1:0]  dsr_q, dsr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [WIN_W:0]    trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial = {rem_q, quo_q[DIVN_W-1]};
    fits  = trial >= {1'b0, dsr_q};
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = CW'(DIVN_W);
    end else if (cnt_q != '0) begin
      rem_d = fits ? WIN_W'(trial - {1'b0, dsr_q}) : trial[WIN_W-1:0];
      quo_d = {quo_q[DIVN_W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

[rtl/core/tws_datapath.sv]
module tws_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tws_pkg::cmd_t              cmd_i,
  output tws_pkg::status_t           status_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [tws_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic [tws_pkg::SEQ_W-1:0]  advertised_seq_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [tws_pkg::SEQ_W-1:0]  segment_start_o,
  output logic [tws_pkg::LEN_W-1:0]  segment_length_o,
  output logic                       resend_o,
  output logic [tws_pkg::WIN_W-1:0]  window_now_o,
  output logic                       stream_done_o,
  output logic                       last_of_run_o
);
  import tws_pkg::*;

  typedef struct packed {
    logic [SEQ_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             rs;
    logic [WIN_W-1:0] win;
    logic             done;
  } res_t;

  // Configuration.
  logic [LEN_W-1:0] seg_q;
  logic [SEQ_W-1:0] stream_q;
  logic [TMO_W-1:0] tmo_q;

  // Sender state.
  logic [SEQ_W:0]     acked1_q, sent1_q, adv_q;
  logic [WIN_W-1:0]   win_q;
  logic [SEGS_W-1:0]  wsegs_q, inflight_q;
  logic [FLIGHT_AW-1:0] fhead_q;
  logic [TIMER_AW-1:0]  thead_q;
  logic [TCNT_W-1:0]    tcount_q;
  logic [STAMP_W-1:0]   ticks_q;
  logic                 popped_q;
  logic [NRES_W-1:0]    nres_q;

  res_t pend_q, out_q, res_new;
  logic pend_v_q, out_v_q;

  logic [SEQ_W-1:0]   flight_rd, tseq_rd;
  logic [STAMP_W-1:0] stamp_rd;

  logic [LEN_W-1:0]   mss;
  logic               done, out_free, tq_full;
  logic [SEQ_W-1:0]   rem_send, rem_ack;
  logic [LEN_W-1:0]   len_send, len_ack;
  logic [STAMP_W-1:0] age;
  logic [TIMER_AW-1:0]  push_slot;
  logic [FLIGHT_AW-1:0] fl_waddr;
  logic [TIMER_AW-1:0]  tm_waddr;
  logic [SEQ_W-1:0]     fl_wdata, tm_wdata;
  logic                 fl_we, tm_we;
  logic [WIN_W-1:0]     cfg_win;
  logic                 div_start, div_busy;
  logic [DIVN_W-1:0]    div_dividend, quot;
  logic [WIN_W-1:0]     div_divisor;
  logic [DIVN_W:0]      grown;
  logic [WIN_W-1:0]     win_grown;
  logic [SEGS_W-1:0]    segs_new;

  assign mss      = (seg_q == '0) ? LEN_W'(1) : seg_q;
  assign done     = acked1_q >= {1'b0, stream_q};
  assign out_free = !out_v_q || out_ready_i;
  assign age      = ticks_q - stamp_rd;
  assign tq_full  = tcount_q == TCNT_W'(TIMER_DEPTH);
  assign push_slot = tq_full ? '0 : TIMER_AW'(thead_q + tcount_q[TIMER_AW-1:0]);

  assign rem_send = stream_q - sent1_q[SEQ_W-1:0];
  assign rem_ack  = stream_q - acked1_q[SEQ_W-1:0];
  assign len_send = (rem_send > SEQ_W'(mss)) ? mss : rem_send[LEN_W-1:0];
  assign len_ack  = (rem_ack > SEQ_W'(mss)) ? mss : rem_ack[LEN_W-1:0];

  assign cfg_win = (cfg_data_i[WIN_W-1:0] == '0) ? WIN_W'(1) :
                   (cfg_data_i[WIN_W-1:0] > WIN_CAP) ? WIN_CAP : cfg_data_i[WIN_W-1:0];

  assign grown     = DIVN_W'(win_q) + quot;
  assign win_grown = (grown > (DIVN_W+1)'(WIN_CAP)) ? WIN_CAP : grown[WIN_W-1:0];
  assign segs_new  = (quot == '0) ? SEGS_W'(1) :
                     (quot > DIVN_W'(MAX_WIN_SEGS)) ? SEGS_W'(MAX_WIN_SEGS) : quot[SEGS_W-1:0];

  // One multiplier feeding the divider's load register.
  assign div_start    = cmd_i.grow_load || cmd_i.seg_load;
  assign div_dividend = cmd_i.grow_load ? DIVN_W'(mss) * DIVN_W'(mss) : DIVN_W'(win_q);
  assign div_divisor  = cmd_i.grow_load ? win_q : WIN_W'(mss);

  tws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  always_comb begin
    fl_we    = cmd_i.resend || cmd_i.send;
    tm_we    = fl_we;
    fl_waddr = cmd_i.resend ? '0 : FLIGHT_AW'(fhead_q + inflight_q[FLIGHT_AW-1:0]);
    tm_waddr = cmd_i.resend ? thead_q : push_slot;
    fl_wdata = cmd_i.resend ? acked1_q[SEQ_W-1:0] : sent1_q[SEQ_W-1:0];
    tm_wdata = fl_wdata;
  end

  tws_ram #(.Width(SEQ_W), .Depth(MAX_WIN_SEGS)) u_flight (
    .clk_i (clk_i), .we_i (fl_we), .waddr_i (fl_waddr), .wdata_i (fl_wdata),
    .raddr_i (fhead_q), .rdata_o (flight_rd)
  );

  tws_ram #(.Width(SEQ_W), .Depth(TIMER_DEPTH)) u_timer_seq (
    .clk_i (clk_i), .we_i (tm_we), .waddr_i (tm_waddr), .wdata_i (tm_wdata),
    .raddr_i (thead_q), .rdata_o (tseq_rd)
  );

  tws_ram #(.Width(STAMP_W), .Depth(TIMER_DEPTH)) u_timer_stamp (
    .clk_i (clk_i), .we_i (tm_we), .waddr_i (tm_waddr), .wdata_i (ticks_q),
    .raddr_i (thead_q), .rdata_o (stamp_rd)
  );

  always_comb begin
    res_new = '0;
    if (cmd_i.resend) begin
      res_new.start = acked1_q[SEQ_W-1:0];
      res_new.len   = len_ack;
      res_new.rs    = 1'b1;
      res_new.win   = WIN_W'(mss);
    end else if (cmd_i.send) begin
      res_new.start = sent1_q[SEQ_W-1:0];
      res_new.len   = len_send;
      res_new.win   = win_q;
    end else begin
      res_new.start = stream_q;
      res_new.win   = win_q;
      res_new.done  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q      <= SEG_RESET;
      stream_q   <= STREAM_RESET;
      tmo_q      <= TIMEOUT_RESET;
      acked1_q   <= '0;
      sent1_q    <= '0;
      win_q      <= WINDOW_RESET;
      wsegs_q    <= SEGS_W'(1);
      inflight_q <= '0;
      fhead_q    <= '0;
      thead_q    <= '0;
      tcount_q   <= '0;
      ticks_q    <= '0;
      popped_q   <= 1'b0;
      nres_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SEGMENT: seg_q    <= cfg_data_i[LEN_W-1:0];
          CFG_STREAM:  stream_q <= cfg_data_i[SEQ_W-1:0];
          CFG_WINDOW:  win_q    <= cfg_win;
          CFG_TIMEOUT: tmo_q    <= cfg_data_i[TMO_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        nres_q   <= '0;
        popped_q <= 1'b0;
        // Acks beyond what was sent are clamped; only ticks advance the time count.
        adv_q    <= ({1'b0, advertised_seq_i} > sent1_q) ? sent1_q
                                                          : {1'b0, advertised_seq_i};
        if (cmd_i.tick) begin
          ticks_q <= ticks_q + STAMP_W'(1);
        end
      end
      if (cmd_i.tmo_clear) begin
        tcount_q <= '0;
      end
      if (cmd_i.resend) begin
        win_q      <= WIN_W'(mss);
        wsegs_q    <= SEGS_W'(1);
        fhead_q    <= '0;
        inflight_q <= SEGS_W'(1);
        nres_q     <= nres_q + NRES_W'(1);
      end
      if (cmd_i.pop_flight) begin
        fhead_q    <= fhead_q + FLIGHT_AW'(1);
        inflight_q <= inflight_q - SEGS_W'(1);
        popped_q   <= 1'b1;
      end
      if (cmd_i.ack_update && (adv_q > acked1_q)) begin
        acked1_q <= adv_q;
      end
      if (cmd_i.grow_take) begin
        win_q <= win_grown;
      end
      if (cmd_i.seg_take) begin
        wsegs_q <= segs_new;
      end
      if (cmd_i.pop_timer) begin
        thead_q  <= thead_q + TIMER_AW'(1);
        tcount_q <= tcount_q - TCNT_W'(1);
      end
      if (cmd_i.send) begin
        inflight_q <= inflight_q + SEGS_W'(1);
        sent1_q    <= sent1_q + (SEQ_W+1)'(len_send);
        nres_q     <= nres_q + NRES_W'(1);
        if (tq_full) begin
          thead_q  <= '0;
          tcount_q <= TCNT_W'(1);
        end else begin
          tcount_q <= tcount_q + TCNT_W'(1);
        end
      end
      // Results sit in a pending stage until the next one shows whether
      // they close the run.
      if (cmd_i.resend || cmd_i.send || cmd_i.status) begin
        pend_v_q <= 1'b1;
        pend_q   <= res_new;
        if (pend_v_q) begin
          out_v_q <= 1'b1;
          out_q   <= pend_q;
        end else if (out_ready_i) begin
          out_v_q <= 1'b0;
        end
      end else if (cmd_i.drain) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
        out_q    <= pend_q;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  logic last_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.drain) begin
      last_q <= 1'b1;
    end else if ((cmd_i.resend || cmd_i.send || cmd_i.status) && pend_v_q) begin
      last_q <= 1'b0;
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.tq_empty   = tcount_q == '0;
    status_o.expired    = age >= STAMP_W'(tmo_q);
    status_o.done       = done;
    status_o.flight_pop = (inflight_q != '0) && ({1'b0, flight_rd} < adv_q);
    status_o.timer_pop  = (tcount_q != '0) && ({1'b0, tseq_rd} < acked1_q);
    status_o.popped     = popped_q;
    status_o.div_busy   = div_busy;
    status_o.can_send   = (nres_q < NRES_W'(RESULT_LIMIT)) && (inflight_q < wsegs_q) &&
                          (sent1_q < {1'b0, stream_q});
    status_o.n_zero     = nres_q == '0;
    status_o.emit_ok    = !pend_v_q || out_free;
    status_o.out_free   = out_free;
    status_o.pend_v     = pend_v_q;
  end

  assign out_valid_o      = out_v_q;
  assign segment_start_o  = out_q.start;
  assign segment_length_o = out_q.len;
  assign resend_o         = out_q.rs;
  assign window_now_o     = out_q.win;
  assign stream_done_o    = out_q.done;
  assign last_of_run_o    = last_q;

endmodule

[rtl/core/tws_ctrl.sv]
module tws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               command_i,
  output logic               in_ready_o,
  input  tws_pkg::status_t   status_i,
  output tws_pkg::cmd_t      cmd_o
);
  import tws_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_T_RD  = 14'b00000000000010,
    S_T_CHK = 14'b00000000000100,
    S_A_RD  = 14'b00000000001000,
    S_A_CHK = 14'b00000000010000,
    S_G_MUL = 14'b00000000100000,
    S_G_DIV = 14'b00000001000000,
    S_S_LD  = 14'b00000010000000,
    S_S_DIV = 14'b00000100000000,
    S_P_RD  = 14'b00001000000000,
    S_P_CHK = 14'b00010000000000,
    S_SEND  = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_DRAIN = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cmd_o.tick   = !command_i;
          state_d      = command_i ? S_A_RD : S_T_RD;
        end
      end
      S_T_RD: state_d = status_i.tq_empty ? S_SEND : S_T_CHK;
      S_T_CHK: begin
        if (!status_i.expired) begin
          state_d = S_SEND;
        end else if (status_i.done) begin
          cmd_o.tmo_clear = 1'b1;
          state_d         = S_SEND;
        end else if (status_i.emit_ok) begin
          cmd_o.resend = 1'b1;
          state_d      = S_SEND;
        end
      end
      S_A_RD: state_d = S_A_CHK;
      S_A_CHK: begin
        if (status_i.flight_pop) begin
          cmd_o.pop_flight = 1'b1;
          state_d          = S_A_RD;
        end else if (status_i.popped) begin
          cmd_o.ack_update = 1'b1;
          state_d          = S_G_MUL;
        end else begin
          state_d = S_P_RD;
        end
      end
      S_G_MUL: begin
        cmd_o.grow_load = 1'b1;
        state_d         = S_G_DIV;
      end
      S_G_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.grow_take = 1'b1;
          state_d         = S_S_LD;
        end
      end
      S_S_LD: begin
        cmd_o.seg_load = 1'b1;
        state_d        = S_S_DIV;
      end
      S_S_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.seg_take = 1'b1;
          state_d        = S_P_RD;
        end
      end
      S_P_RD: state_d = S_P_CHK;
      S_P_CHK: begin
        if (status_i.timer_pop) begin
          cmd_o.pop_timer = 1'b1;
          state_d         = S_P_RD;
        end else begin
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (!status_i.can_send) begin
          state_d = S_FIN;
        end else if (status_i.emit_ok) begin
          cmd_o.send = 1'b1;
        end
      end
      S_FIN: begin
        if (!(status_i.n_zero && status_i.done)) begin
          state_d = S_DRAIN;
        end else if (status_i.emit_ok) begin
          cmd_o.status = 1'b1;
          state_d      = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pend_v) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.drain = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/tcp_window_sender_control_unit.sv]
// Sender-side congestion window controller for a byte stream.
// Input channel (in_valid_i/in_ready_o): one event per transfer, a tick of
// time or an acknowledgement up to advertised_seq_i. Output channel
// (out_valid_o/out_ready_i): segment commands, a timeout resend, or a single
// stream-finished status; last_of_run_o marks the final result of an event.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i);
// the user must use it only while the block is idle, which the block does
// not enforce. A window write also reloads the window. Events are handled
// one at a time. A tick checks the oldest timer, then issues new segments;
// an acknowledgement retires segments, and if any retired grows the window
// and recomputes the segment count (two passes of the shared 32-step
// divider), then retires timers and issues new segments. The first result
// of an event leaves after the second is made or the event ends. in_ready_o
// is high only in the idle state. A stalled receiver holds the sequencer at
// its next result through the output register and a one-deep pending stage.
// After reset the window holds 5900 bytes, one segment may be outstanding and
// both queues are empty; the segment and timer stores need no clearing.
module tcp_window_sender_control_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [tws_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [tws_pkg::SEQ_W-1:0]  advertised_seq_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tws_pkg::SEQ_W-1:0]  segment_start_o,
  output logic [tws_pkg::LEN_W-1:0]  segment_length_o,
  output logic                       resend_o,
  output logic [tws_pkg::WIN_W-1:0]  window_now_o,
  output logic                       stream_done_o,
  output logic                       last_of_run_o
);
  import tws_pkg::*;
`include "tcp_window_sender_control_unit_defines.svh"

  cmd_t    cmd;
  status_t st;

  // The sequencer decides every step; the datapath holds all sender state.
  tws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  tws_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (st),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .advertised_seq_i (advertised_seq_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .segment_start_o  (segment_start_o),
    .segment_length_o (segment_length_o),
    .resend_o         (resend_o),
    .window_now_o     (window_now_o),
    .stream_done_o    (stream_done_o),
    .last_of_run_o    (last_of_run_o)
  );

  // Idle means every result of the last event has left the pending stage.
  `TWS_ASSERT_IMPL(a_idle_no_pending, clk_i, rst_ni, in_ready_o, !st.pend_v)
  // A segment is only issued when the window has room and the output can move.
  `TWS_ASSERT_IMPL(a_send_allowed, clk_i, rst_ni, cmd.send, st.can_send && st.emit_ok)
  // At most one result is made per cycle.
  `TWS_ASSERT(a_one_result, clk_i, rst_ni,
              $onehot0({cmd.resend, cmd.send, cmd.status, cmd.drain}))
  // The finished status carries no bytes and is never a resend.
  `TWS_ASSERT_IMPL(a_status_empty, clk_i, rst_ni, out_valid_o && stream_done_o,
                   segment_length_o == '0 && !resend_o)

endmodule

[sim/tws_tb_pkg.sv]
`timescale 1ns / 1ps
package tws_tb_pkg;

  // Event kinds carried by command_i.
  typedef enum bit {
    EV_TICK = 1'b0,
    EV_ACK  = 1'b1
  } event_kind_e;

endpackage

[sim/tws_window_checker.sv]
`timescale 1ns / 1ps
module tws_window_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [tws_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      command_i,
  input  logic [tws_pkg::SEQ_W-1:0] advertised_seq_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [tws_pkg::SEQ_W-1:0] segment_start_i,
  input  logic [tws_pkg::LEN_W-1:0] segment_length_i,
  input  logic                      resend_i,
  input  logic [tws_pkg::WIN_W-1:0] window_now_i,
  input  logic                      stream_done_i,
  input  logic                      last_of_run_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        events_o,
  output int                        segments_o
);
  import tws_pkg::*;
  import tws_tb_pkg::*;

  typedef struct {
    logic [SEQ_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             resend;
    logic [WIN_W-1:0] win;
    logic             done;
    logic             last;
  } seg_cmd_t;

  seg_cmd_t segs_due[$];

  int unsigned mss_reg, stream_reg, init_win_reg, timeout_reg;
  int          acked_to, sent_to;
  int unsigned win_bytes, win_segs, outstanding, fl_head;
  int unsigned fl_start[MAX_WIN_SEGS];
  int unsigned tm_seq[TIMER_DEPTH];
  int unsigned tm_stamp[TIMER_DEPTH];
  int unsigned tm_head, tm_count;
  bit [31:0]   ticks;

  function automatic int unsigned eff_mss();
    return (mss_reg == 0) ? 1 : mss_reg;
  endfunction

  function automatic bit all_acked();
    return acked_to + 1 >= int'(stream_reg);
  endfunction

  function automatic int unsigned clamp_win(int unsigned w);
    if (w == 0) return 1;
    return (w > WIN_CAP) ? WIN_CAP : w;
  endfunction

  function automatic void add_cmd(int unsigned start, int unsigned len, bit rs, bit done);
    seg_cmd_t c;
    c.start  = start[SEQ_W-1:0];
    c.len    = len[LEN_W-1:0];
    c.resend = rs;
    c.win    = win_bytes[WIN_W-1:0];
    c.done   = done;
    c.last   = 1'b0;
    segs_due.push_back(c);
  endfunction

  function automatic void arm_timer(int unsigned start);
    int unsigned slot;
    if (tm_count >= TIMER_DEPTH) begin
      tm_head  = 0;
      tm_count = 0;
    end
    slot = (tm_head + tm_count) % TIMER_DEPTH;
    tm_seq[slot]   = start;
    tm_stamp[slot] = ticks;
    tm_count++;
  endfunction

  // Works out every segment command one event causes and queues them.
  function automatic void predict_event(bit kind, logic [SEQ_W-1:0] adv_in);
    int          n;
    int          adv;
    bit          retired;
    int unsigned h, start, len, m, segs;
    longint unsigned w;
    bit [31:0]   age;
    n = 0;
    retired = 0;
    if (kind == EV_TICK) begin
      ticks = ticks + 1;
      h = tm_head % TIMER_DEPTH;
      age = ticks - tm_stamp[h];
      if (tm_count > 0 && age >= timeout_reg) begin
        if (all_acked()) begin
          tm_count = 0;
        end else begin
          start = acked_to + 1;
          len = stream_reg - start;
          if (len > eff_mss()) len = eff_mss();
          tm_seq[h]   = start;
          tm_stamp[h] = ticks;
          win_bytes   = eff_mss();
          win_segs    = 1;
          fl_head     = 0;
          fl_start[0] = start;
          outstanding = 1;
          add_cmd(start, len, 1'b1, 1'b0);
          n++;
        end
      end
    end else begin
      adv = int'(adv_in);
      if (adv > sent_to + 1) adv = sent_to + 1;
      while (outstanding > 0 && int'(fl_start[fl_head % MAX_WIN_SEGS]) < adv) begin
        fl_head = (fl_head + 1) % MAX_WIN_SEGS;
        outstanding--;
        retired = 1;
      end
      if (retired) begin
        if (adv - 1 > acked_to) acked_to = adv - 1;
        m = eff_mss();
        w = longint'(win_bytes) + (longint'(m) * m) / win_bytes;
        win_bytes = (w > WIN_CAP) ? WIN_CAP : int'(w);
        segs = win_bytes / m;
        if (segs < 1) segs = 1;
        if (segs > MAX_WIN_SEGS) segs = MAX_WIN_SEGS;
        win_segs = segs;
      end
      while (tm_count > 0 && int'(tm_seq[tm_head % TIMER_DEPTH]) <= acked_to) begin
        tm_head = (tm_head + 1) % TIMER_DEPTH;
        tm_count--;
      end
    end
    // Fill the window with new segments, bounded per event.
    while (n < RESULT_LIMIT && outstanding < win_segs && sent_to + 1 < int'(stream_reg)) begin
      start = sent_to + 1;
      len = stream_reg - start;
      if (len > eff_mss()) len = eff_mss();
      fl_start[(fl_head + outstanding) % MAX_WIN_SEGS] = start;
      outstanding++;
      arm_timer(start);
      sent_to += int'(len);
      add_cmd(start, len, 1'b0, 1'b0);
      n++;
    end
    // A finished stream reports its status when nothing else goes out.
    if (n == 0 && all_acked()) begin
      add_cmd(stream_reg, 0, 1'b0, 1'b1);
      n++;
    end
    if (n > 0) segs_due[$].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    seg_cmd_t exp_c;
    if (!rst_ni) begin
      mss_reg      = SEG_RESET;
      stream_reg   = STREAM_RESET;
      init_win_reg = WINDOW_RESET;
      timeout_reg  = TIMEOUT_RESET;
      acked_to     = -1;
      sent_to      = -1;
      win_bytes    = clamp_win(init_win_reg);
      win_segs     = 1;
      outstanding  = 0;
      fl_head      = 0;
      tm_head      = 0;
      tm_count     = 0;
      ticks        = 0;
      segs_due.delete();
      errors_o     = 0;
      events_o     = 0;
      segments_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        segments_o++;
        if (segs_due.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected transfer start=%0d len=%0d", $time,
                   segment_start_i, segment_length_i);
        end else begin
          exp_c = segs_due.pop_front();
          if (segment_start_i !== exp_c.start || segment_length_i !== exp_c.len ||
              resend_i !== exp_c.resend || window_now_i !== exp_c.win ||
              stream_done_i !== exp_c.done || last_of_run_i !== exp_c.last) begin
            errors_o++;
            $display("%0t: mismatch expected start=%0d len=%0d rs=%0b win=%0d done=%0b last=%0b",
                     $time, exp_c.start, exp_c.len, exp_c.resend, exp_c.win, exp_c.done,
                     exp_c.last);
            $display("%0t:          actual   start=%0d len=%0d rs=%0b win=%0d done=%0b last=%0b",
                     $time, segment_start_i, segment_length_i, resend_i, window_now_i,
                     stream_done_i, last_of_run_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        events_o++;
        predict_event(command_i, advertised_seq_i);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SEGMENT: mss_reg = cfg_data_i[LEN_W-1:0];
          CFG_STREAM:  stream_reg = cfg_data_i[SEQ_W-1:0];
          CFG_WINDOW: begin
            init_win_reg = cfg_data_i[WIN_W-1:0];
            win_bytes = clamp_win(init_win_reg);
          end
          CFG_TIMEOUT: timeout_reg = cfg_data_i[TMO_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = segs_due.size();
  end

endmodule

[sim/tcp_window_sender_control_unit_tb.sv]
`timescale 1ns / 1ps
module tcp_window_sender_control_unit_tb;
  import tws_pkg::*;
  import tws_tb_pkg::*;

  // The block handles one event at a time; this margin covers even an
  // acknowledgement that retires a full window, grows it and retires a full
  // timer queue, when that event produced no transfer at all.
  localparam int SETTLE_CYCLES = 1000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_index_i = CFG_SEGMENT;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             command_i = EV_TICK;
  logic [SEQ_W-1:0] advertised_seq_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [SEQ_W-1:0] segment_start_o;
  logic [LEN_W-1:0] segment_length_o;
  logic             resend_o;
  logic [WIN_W-1:0] window_now_o;
  logic             stream_done_o;
  logic             last_of_run_o;

  int errors, pending, events, segments;

  // When this is clear both sides run back to back with no idle cycles.
  bit gaps_on = 1'b1;
  int unsigned stream_cur;
  int unsigned mss_cur;

  always #4 clk_i = ~clk_i;

  tcp_window_sender_control_unit u_top (.*);

  tws_window_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .advertised_seq_i,
    .out_valid_i(out_valid_o), .out_ready_i, .segment_start_i(segment_start_o),
    .segment_length_i(segment_length_o), .resend_i(resend_o),
    .window_now_i(window_now_o), .stream_done_i(stream_done_o),
    .last_of_run_i(last_of_run_o),
    .errors_o(errors), .pending_o(pending), .events_o(events), .segments_o(segments)
  );

  // The receiver draws a stall before every transfer it takes.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = gaps_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Sends one event; valid stays high into the next call when no gap is drawn.
  task automatic send_event(bit kind, logic [SEQ_W-1:0] adv);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= kind;
    advertised_seq_i <= adv;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Drops valid, waits for every expected transfer, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four registers on consecutive edges; only called while idle.
  task automatic program_regs(int unsigned mss, int unsigned strm, int unsigned win,
                              int unsigned tmo);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SEGMENT;
    cfg_data_i  <= CFG_W'(mss);
    @(posedge clk_i);
    cfg_index_i <= CFG_STREAM;
    cfg_data_i  <= CFG_W'(strm);
    @(posedge clk_i);
    cfg_index_i <= CFG_WINDOW;
    cfg_data_i  <= CFG_W'(win);
    @(posedge clk_i);
    cfg_index_i <= CFG_TIMEOUT;
    cfg_data_i  <= CFG_W'(tmo);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    mss_cur    = mss;
    stream_cur = strm;
  endtask

  // Mostly acknowledgements inside the stream so that segments retire and the
  // window grows; now and then a tick to fire timers, or a fully random value.
  task automatic random_events(int count);
    int unsigned hi;
    for (int k = 0; k < count; k++) begin
      hi = stream_cur + mss_cur;
      if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
      if ($urandom_range(0, 2) == 0)
        send_event(EV_TICK, SEQ_W'($urandom));
      else if ($urandom_range(0, 7) == 0)
        send_event(EV_ACK, SEQ_W'($urandom));
      else
        send_event(EV_ACK, SEQ_W'($urandom_range(0, hi)));
      if (k % 10 == 0) gaps_on = $urandom_range(0, 3) != 0;
    end
  endtask

  initial begin
    stream_cur = STREAM_RESET;
    mss_cur    = SEG_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: first segment, an ack below the sent point, acks beyond
    // the sent data, and ticks that expire the oldest timer.
    send_event(EV_ACK, 24'd0);
    send_event(EV_TICK, '0);
    send_event(EV_TICK, '0);
    send_event(EV_ACK, 24'hFFFFFF);
    send_event(EV_ACK, 24'd0);
    send_event(EV_ACK, 24'd1000);
    send_event(EV_TICK, 24'hFFFFFF);
    send_event(EV_ACK, 24'd2999);
    drain();

    // Tiny segments and stream: finish the stream, then ticks after it ended.
    program_regs(1, 6, 1, 0);
    send_event(EV_ACK, 24'd3);
    send_event(EV_TICK, '0);
    send_event(EV_ACK, 24'd6);
    send_event(EV_ACK, 24'd6);
    send_event(EV_TICK, '0);
    send_event(EV_TICK, '0);
    drain();

    // Zero segment size and window count as one; zero timeout fires every tick.
    program_regs(0, 40, 0, 0);
    random_events(20);
    drain();

    // Largest values: full segments, the window cap and the longest timeout.
    program_regs(16'hFFFF, 24'hFFFFFF, 23'd4194304, 8'hFF);
    send_event(EV_ACK, 24'hFFFFFF);
    send_event(EV_ACK, 24'hFFFFFF);
    send_event(EV_TICK, '0);
    random_events(10);
    drain();

    // Window write above the cap gets clamped.
    program_regs(200, 6000, 23'h7FFFFF, 3);
    random_events(25);
    drain();

    program_regs(100, 3000, 100, 2);
    random_events(20);
    // Hold back until everything issued so far has come out.
    drain();
    random_events(25);
    drain();

    program_regs(7, 24'd200000, 500, 1);
    random_events(30);
    drain();

    $display("tb: %0d events sent, %0d segment commands checked over seven register settings",
             events, segments);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/tws_pkg.sv
rtl/core/tws_ram.sv
rtl/core/tws_div.sv
rtl/core/tws_datapath.sv
rtl/core/tws_ctrl.sv
rtl/core/tcp_window_sender_control_unit.sv
sim/tws_tb_pkg.sv
sim/tws_window_checker.sv
sim/tcp_window_sender_control_unit_tb.sv
